// File: hdl/pseudocolor_palette_generator_defines.svh
// Assertion macros used by the checker file of the palette generator.
// Depends on nothing; expects aclk and aresetn in the scope of each use.
`ifndef PSEUDOCOLOR_PALETTE_GENERATOR_DEFINES_SVH
`define PSEUDOCOLOR_PALETTE_GENERATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PPG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ppg_pkg.sv
// Types and constants of the pseudocolor palette generator.
// Used by the top level; depends on nothing.
package ppg_pkg;

    localparam int HUE_ONE = 65536;
    localparam logic [23:0] LEVEL_SCALE = 24'd16777150;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_PALETTE_MODE = 3'd0;
    localparam logic [2:0] CFG_ENTRY_COUNT  = 3'd1;
    localparam logic [2:0] CFG_START_RED    = 3'd2;
    localparam logic [2:0] CFG_END_RED      = 3'd3;
    localparam logic [2:0] CFG_START_GREEN  = 3'd4;
    localparam logic [2:0] CFG_END_GREEN    = 3'd5;
    localparam logic [2:0] CFG_START_BLUE   = 3'd6;
    localparam logic [2:0] CFG_END_BLUE     = 3'd7;

    // Palette mode codes.
    localparam logic [2:0] PM_RAMP     = 3'd0;
    localparam logic [2:0] PM_SPEC_A6  = 3'd1;
    localparam logic [2:0] PM_SPEC_B6  = 3'd2;
    localparam logic [2:0] PM_SPEC_A5  = 3'd3;
    localparam logic [2:0] PM_SPEC_B5  = 3'd4;
    localparam logic [2:0] PM_BLEND    = 3'd5;

    typedef enum logic [1:0] {MC_RAMP, MC_SPEC_A, MC_SPEC_B, MC_BLEND} mode_class_t;
    typedef enum logic [1:0] {CH_RED, CH_GREEN, CH_BLUE} chan_t;
    typedef enum logic [2:0] {QD_1, QD_3, QD_4, QD_7, QD_8, QD_12, QD_100} qdiv_t;

    // ceil(2^24 / q): exact floor division of values below 2^15 after a 24-bit shift.
    function automatic logic [24:0] level_recip(input qdiv_t q);
        logic [24:0] m;
        case (q)
            QD_1:    m = 25'd16777216;
            QD_3:    m = 25'd5592406;
            QD_4:    m = 25'd4194304;
            QD_7:    m = 25'd2396746;
            QD_8:    m = 25'd2097152;
            QD_12:   m = 25'd1398102;
            QD_100:  m = 25'd167773;
            default: m = 25'd16777216;
        endcase
        return m;
    endfunction

endpackage

// File: hdl/ppg_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Standalone; used by the top level to derive per-count constants.
module ppg_sdiv #(
    parameter int WN = 32,
    parameter int WD = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [WN-1:0] dividend,
    input  logic [WD-1:0] divisor,
    output logic          busy,
    output logic [WN-1:0] quotient
);
    localparam int CW = $clog2(WN + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [WD-1:0] rem_reg;
    logic [WN-1:0] quo_reg;
    logic [WD:0]   shifted;
    logic [WD:0]   diff;
    logic          ge;

    always_comb begin
        shifted = {rem_reg, quo_reg[WN-1]};
        diff    = shifted - {1'b0, divisor};
        ge      = (shifted >= {1'b0, divisor});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(WN);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[WD-1:0] : shifted[WD-1:0];
            quo_reg <= {quo_reg[WN-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/ppg_rdiv.sv
// Three-stage pipelined divider by a fixed divisor through its reciprocal.
// Standalone; the top level supplies floor((2^32-1)/d) and per-stage loads.
module ppg_rdiv #(
    parameter int NW = 29
) (
    input  logic          aclk,
    input  logic [2:0]    stage_ld,
    input  logic [NW-1:0] n_in,
    input  logic [10:0]   divisor,
    input  logic [31:0]   recip,
    output logic [NW-1:0] quotient
);
    logic [NW+31:0] prod;
    logic [NW+10:0] qd;
    logic [NW+10:0] rem_full;
    logic [NW-1:0]  qa_reg;
    logic [NW-1:0]  na_reg;
    logic [NW-1:0]  qb_reg;
    logic [11:0]    remb_reg;
    logic [NW-1:0]  qc_reg;

    // The estimate is low by at most one, so one compare fixes it.
    always_comb begin
        prod     = (NW+32)'(n_in) * (NW+32)'(recip);
        qd       = (NW+11)'(qa_reg) * (NW+11)'(divisor);
        rem_full = (NW+11)'(na_reg) - qd;
    end

    always_ff @(posedge aclk) begin
        if (stage_ld[0]) begin
            qa_reg <= prod[NW+31:32];
            na_reg <= n_in;
        end
        if (stage_ld[1]) begin
            qb_reg   <= qa_reg;
            remb_reg <= rem_full[11:0];
        end
        if (stage_ld[2]) begin
            qc_reg <= (remb_reg >= {1'b0, divisor}) ? qb_reg + NW'(1) : qb_reg;
        end
    end

    assign quotient = qc_reg;

endmodule

// File: hdl/pseudocolor_palette_generator.sv
// An accepted request moves through the stage registers to its result on m_tvalid.
// One request per cycle unless m_tready stalls; every stage has its own valid bit.
// After reset and after every configuration write, two serial dividers derive the
// per-count constants with s_tready low. Reset is synchronous and active low; it
// restores the register defaults.
// Package ppg_pkg; submodules ppg_sdiv and ppg_rdiv.
module pseudocolor_palette_generator #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // entry_index[9:0], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red_level[7:0], green_level[15:8], blue_level[23:16]
);
    localparam logic [10:0] CMAX = 11'((MAX_ENTRIES > 2047) ? 2047 : MAX_ENTRIES);
    localparam int U = ppg_pkg::HUE_ONE;

    // Configuration registers.
    logic [2:0]  palette_mode_reg;
    logic [10:0] entry_count_reg;
    logic [15:0] start_red_reg, end_red_reg, start_green_reg, end_green_reg;
    logic [15:0] start_blue_reg, end_blue_reg;
    logic        start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_mode_reg <= ppg_pkg::PM_RAMP;
            entry_count_reg  <= 11'd1024;
            start_red_reg    <= 16'd0;
            end_red_reg      <= 16'hFFFF;
            start_green_reg  <= 16'd0;
            end_green_reg    <= 16'hFFFF;
            start_blue_reg   <= 16'd0;
            end_blue_reg     <= 16'hFFFF;
            start_reg        <= 1'b1;
        end else begin
            start_reg <= cfg_we;
            if (cfg_we) begin
                unique case (cfg_addr)
                    ppg_pkg::CFG_PALETTE_MODE: palette_mode_reg <= cfg_wdata[2:0];
                    ppg_pkg::CFG_ENTRY_COUNT:  entry_count_reg  <= cfg_wdata[10:0];
                    ppg_pkg::CFG_START_RED:    start_red_reg    <= cfg_wdata;
                    ppg_pkg::CFG_END_RED:      end_red_reg      <= cfg_wdata;
                    ppg_pkg::CFG_START_GREEN:  start_green_reg  <= cfg_wdata;
                    ppg_pkg::CFG_END_GREEN:    end_green_reg    <= cfg_wdata;
                    ppg_pkg::CFG_START_BLUE:   start_blue_reg   <= cfg_wdata;
                    ppg_pkg::CFG_END_BLUE:     end_blue_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Effective count minus one, and the constants derived from it.
    logic [10:0] cnt_eff;
    logic [10:0] cm1;
    logic [31:0] recip;
    logic [10:0] ramp_step;
    logic        r_busy, k_busy, busy;

    always_comb begin
        if (entry_count_reg < 11'd2) begin
            cnt_eff = 11'd2;
        end else if (entry_count_reg > CMAX) begin
            cnt_eff = CMAX;
        end else begin
            cnt_eff = entry_count_reg;
        end
        cm1 = cnt_eff - 11'd1;
    end

    ppg_sdiv #(.WN(32), .WD(11)) u_recip_div (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg),
        .dividend(32'hFFFF_FFFF), .divisor(cm1), .busy(r_busy), .quotient(recip)
    );

    ppg_sdiv #(.WN(11), .WD(11)) u_step_div (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg),
        .dividend(11'd1279), .divisor(cm1), .busy(k_busy), .quotient(ramp_step)
    );

    assign busy = start_reg | r_busy | k_busy;

    // Stage valid bits and load enables; stage 8 is the output register.
    logic [7:1] v_reg;
    logic [8:1] ld;
    logic       m_tvalid_reg;

    always_comb begin
        ld[8] = !m_tvalid_reg | m_tready;
        for (int i = 7; i >= 1; i--) begin
            ld[i] = !v_reg[i] | ld[i+1];
        end
    end

    assign s_tready = ld[1] & !busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (ld[1]) begin
                v_reg[1] <= s_tvalid & s_tready;
            end
            for (int i = 2; i <= 7; i++) begin
                if (ld[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
            if (ld[8]) begin
                m_tvalid_reg <= v_reg[7];
            end
        end
    end

    // Stage 1: clamp the index and classify the mode.
    logic [9:0]               n_eff;
    ppg_pkg::mode_class_t     mc;
    logic [9:0]               s1_n_reg;
    ppg_pkg::mode_class_t     s1_mc_reg;
    logic                     s1_span6_reg, s1_mode4_reg;

    always_comb begin
        n_eff = ({1'b0, s_tdata[9:0]} > cm1) ? cm1[9:0] : s_tdata[9:0];
        unique case (palette_mode_reg) inside
            ppg_pkg::PM_SPEC_A6, ppg_pkg::PM_SPEC_A5: mc = ppg_pkg::MC_SPEC_A;
            ppg_pkg::PM_SPEC_B6, ppg_pkg::PM_SPEC_B5: mc = ppg_pkg::MC_SPEC_B;
            ppg_pkg::PM_BLEND:                        mc = ppg_pkg::MC_BLEND;
            default:                                  mc = ppg_pkg::MC_RAMP;
        endcase
    end

    // Stage 2: numerators and the ramp position.
    logic [12:0] sn;
    logic [10:0] cm1_n;
    logic [27:0] num_r, num_g, num_b;
    logic [20:0] kp;
    logic [28:0] s2_hue_reg;
    logic [18:0] s2_br_reg, s2_bg_reg, s2_bb_reg;
    logic [10:0] s2_k_reg;
    ppg_pkg::mode_class_t s2_mc_reg;
    logic        s2_mode4_reg;

    always_comb begin
        sn    = 13'(s1_n_reg) * (s1_span6_reg ? 13'd6 : 13'd5);
        cm1_n = cm1 - {1'b0, s1_n_reg};
        num_r = 28'(28'(start_red_reg) * 28'(cm1_n)) + 28'(28'(end_red_reg) * 28'(s1_n_reg));
        num_g = 28'(28'(start_green_reg) * 28'(cm1_n))
              + 28'(28'(end_green_reg) * 28'(s1_n_reg));
        num_b = 28'(28'(start_blue_reg) * 28'(cm1_n)) + 28'(28'(end_blue_reg) * 28'(s1_n_reg));
        kp    = 21'(s1_n_reg) * 21'(ramp_step);
    end

    // Stages 3 to 5: division by count minus one.
    logic [28:0] hue_q;
    logic [18:0] bq_r, bq_g, bq_b;

    ppg_rdiv #(.NW(29)) u_hue_div (
        .aclk(aclk), .stage_ld(ld[5:3]), .n_in(s2_hue_reg),
        .divisor(cm1), .recip(recip), .quotient(hue_q)
    );
    ppg_rdiv #(.NW(19)) u_red_div (
        .aclk(aclk), .stage_ld(ld[5:3]), .n_in(s2_br_reg),
        .divisor(cm1), .recip(recip), .quotient(bq_r)
    );
    ppg_rdiv #(.NW(19)) u_green_div (
        .aclk(aclk), .stage_ld(ld[5:3]), .n_in(s2_bg_reg),
        .divisor(cm1), .recip(recip), .quotient(bq_g)
    );
    ppg_rdiv #(.NW(19)) u_blue_div (
        .aclk(aclk), .stage_ld(ld[5:3]), .n_in(s2_bb_reg),
        .divisor(cm1), .recip(recip), .quotient(bq_b)
    );

    ppg_pkg::mode_class_t s3_mc_reg, s4_mc_reg, s5_mc_reg;
    logic        s3_mode4_reg, s4_mode4_reg, s5_mode4_reg;
    logic [10:0] s3_k_reg, s4_k_reg, s5_k_reg;

    // Stage 6: hue segment decode, ramp legs, blend clamp.
    logic [18:0]          h;
    logic signed [25:0]   hs;
    logic signed [25:0]   p;
    logic [7:0]           br, bg, bb;
    logic                 is_spec;
    ppg_pkg::chan_t       vsel;
    ppg_pkg::qdiv_t       qsel;
    logic [10:0]          k;

    always_comb begin
        h       = hue_q[18:0] + (s5_mode4_reg ? 19'(U) : 19'd0);
        hs      = $signed({7'b0, h});
        k       = s5_k_reg;
        p       = '0;
        br      = 8'd0;
        bg      = 8'd0;
        bb      = 8'd0;
        is_spec = 1'b0;
        vsel    = ppg_pkg::CH_RED;
        qsel    = ppg_pkg::QD_1;
        case (s5_mc_reg)
            ppg_pkg::MC_SPEC_A: begin
                is_spec = 1'b1;
                if (hs < U) begin
                    br = 8'd255; vsel = ppg_pkg::CH_GREEN; qsel = ppg_pkg::QD_100;
                    p = 26'(65 * hs);
                end else if (hs < 2 * U) begin
                    br = 8'd255; vsel = ppg_pkg::CH_GREEN; qsel = ppg_pkg::QD_100;
                    p = 26'(65 * U + 35 * (hs - U));
                end else if (10 * hs < 23 * U) begin
                    bg = 8'd255; vsel = ppg_pkg::CH_RED; qsel = ppg_pkg::QD_3;
                    p = 26'(3 * U - 2 * (hs - 2 * U));
                end else if (hs < 3 * U) begin
                    bg = 8'd255; vsel = ppg_pkg::CH_RED; qsel = ppg_pkg::QD_7;
                    p = 26'(8 * (3 * U - hs));
                end else if (10 * hs < 34 * U) begin
                    bg = 8'd255; vsel = ppg_pkg::CH_BLUE; qsel = ppg_pkg::QD_8;
                    p = 26'(17 * (hs - 3 * U));
                end else if (hs < 4 * U) begin
                    bg = 8'd255; vsel = ppg_pkg::CH_BLUE; qsel = ppg_pkg::QD_4;
                    p = hs;
                end else if (hs < 5 * U) begin
                    bb = 8'd255; vsel = ppg_pkg::CH_GREEN; qsel = ppg_pkg::QD_1;
                    p = 26'(5 * U - hs);
                end else begin
                    bb = 8'd255; vsel = ppg_pkg::CH_RED; qsel = ppg_pkg::QD_1;
                    p = 26'(hs - 5 * U);
                end
            end
            ppg_pkg::MC_SPEC_B: begin
                is_spec = 1'b1;
                if (hs < U) begin
                    bb = 8'd255; vsel = ppg_pkg::CH_RED; qsel = ppg_pkg::QD_1;
                    p = 26'(U - hs);
                end else if (hs < 2 * U) begin
                    bb = 8'd255; vsel = ppg_pkg::CH_GREEN; qsel = ppg_pkg::QD_1;
                    p = 26'(hs - U);
                end else if (10 * hs < 24 * U) begin
                    bg = 8'd255; vsel = ppg_pkg::CH_BLUE; qsel = ppg_pkg::QD_8;
                    p = 26'(8 * U - 3 * (hs - 2 * U));
                end else if (hs < 3 * U) begin
                    bg = 8'd255; vsel = ppg_pkg::CH_BLUE; qsel = ppg_pkg::QD_12;
                    p = 26'(17 * (3 * U - hs));
                end else if (10 * hs < 37 * U) begin
                    bg = 8'd255; vsel = ppg_pkg::CH_RED; qsel = ppg_pkg::QD_7;
                    p = 26'(8 * (hs - 3 * U));
                end else if (hs < 4 * U) begin
                    bg = 8'd255; vsel = ppg_pkg::CH_RED; qsel = ppg_pkg::QD_3;
                    p = 26'(2 * hs - 5 * U);
                end else if (hs < 5 * U) begin
                    br = 8'd255; vsel = ppg_pkg::CH_GREEN; qsel = ppg_pkg::QD_100;
                    p = 26'(100 * U - 35 * (hs - 4 * U));
                end else begin
                    br = 8'd255; vsel = ppg_pkg::CH_GREEN; qsel = ppg_pkg::QD_100;
                    p = 26'(65 * (6 * U - hs));
                end
            end
            ppg_pkg::MC_BLEND: begin
                br = (bq_r > 19'd255) ? 8'd255 : bq_r[7:0];
                bg = (bq_g > 19'd255) ? 8'd255 : bq_g[7:0];
                bb = (bq_b > 19'd255) ? 8'd255 : bq_b[7:0];
            end
            default: begin
                if (k < 11'd256) begin
                    bg = k[7:0]; bb = 8'd255;
                end else if (k < 11'd512) begin
                    bg = 8'd255; bb = 8'(511 - k);
                end else if (k < 11'd768) begin
                    br = 8'(k - 512); bg = 8'd255;
                end else if (k < 11'd1024) begin
                    br = 8'd255; bg = 8'(1023 - k);
                end else begin
                    br = 8'd255;
                    bb = (k > 11'd1279) ? 8'd255 : 8'(k - 1024);
                end
            end
        endcase
    end

    logic [22:0]    s6_p_reg;
    logic [7:0]     s6_r_reg, s6_g_reg, s6_b_reg;
    logic           s6_spec_reg;
    ppg_pkg::chan_t s6_vsel_reg;
    ppg_pkg::qdiv_t s6_qsel_reg;

    // Stage 7: scale the fraction numerator.
    logic [46:0]    x_prod;
    logic [14:0]    s7_w_reg;
    logic [7:0]     s7_r_reg, s7_g_reg, s7_b_reg;
    logic           s7_spec_reg;
    ppg_pkg::chan_t s7_vsel_reg;
    ppg_pkg::qdiv_t s7_qsel_reg;

    assign x_prod = 47'(s6_p_reg) * 47'(ppg_pkg::LEVEL_SCALE);

    // Stage 8: divide by the segment's small constant and assemble.
    logic [39:0] l_prod;
    logic [7:0]  lvl;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [7:0]  r_next, g_next, b_next;

    always_comb begin
        l_prod = 40'(s7_w_reg) * 40'(ppg_pkg::level_recip(s7_qsel_reg));
        lvl    = (l_prod[39:24] > 16'd255) ? 8'd255 : l_prod[31:24];
        r_next = s7_r_reg;
        g_next = s7_g_reg;
        b_next = s7_b_reg;
        if (s7_spec_reg) begin
            case (s7_vsel_reg)
                ppg_pkg::CH_RED:   r_next = lvl;
                ppg_pkg::CH_GREEN: g_next = lvl;
                default:           b_next = lvl;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            s1_n_reg     <= n_eff;
            s1_mc_reg    <= mc;
            s1_span6_reg <= (palette_mode_reg == ppg_pkg::PM_SPEC_A6)
                         || (palette_mode_reg == ppg_pkg::PM_SPEC_B6);
            s1_mode4_reg <= (palette_mode_reg == ppg_pkg::PM_SPEC_B5);
        end
        if (ld[2]) begin
            s2_hue_reg   <= {sn, 16'd0};
            s2_br_reg    <= num_r[26:8];
            s2_bg_reg    <= num_g[26:8];
            s2_bb_reg    <= num_b[26:8];
            s2_k_reg     <= kp[10:0];
            s2_mc_reg    <= s1_mc_reg;
            s2_mode4_reg <= s1_mode4_reg;
        end
        if (ld[3]) begin
            s3_mc_reg <= s2_mc_reg; s3_mode4_reg <= s2_mode4_reg; s3_k_reg <= s2_k_reg;
        end
        if (ld[4]) begin
            s4_mc_reg <= s3_mc_reg; s4_mode4_reg <= s3_mode4_reg; s4_k_reg <= s3_k_reg;
        end
        if (ld[5]) begin
            s5_mc_reg <= s4_mc_reg; s5_mode4_reg <= s4_mode4_reg; s5_k_reg <= s4_k_reg;
        end
        if (ld[6]) begin
            s6_p_reg    <= (p < 0) ? 23'd0 : p[22:0];
            s6_r_reg    <= br;
            s6_g_reg    <= bg;
            s6_b_reg    <= bb;
            s6_spec_reg <= is_spec;
            s6_vsel_reg <= vsel;
            s6_qsel_reg <= qsel;
        end
        if (ld[7]) begin
            s7_w_reg    <= x_prod[46:32];
            s7_r_reg    <= s6_r_reg;
            s7_g_reg    <= s6_g_reg;
            s7_b_reg    <= s6_b_reg;
            s7_spec_reg <= s6_spec_reg;
            s7_vsel_reg <= s6_vsel_reg;
            s7_qsel_reg <= s6_qsel_reg;
        end
        if (ld[8]) begin
            red_reg   <= r_next;
            green_reg <= g_next;
            blue_reg  <= b_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};

endmodule

// File: hdl/ppg_checker.sv
// Port-level checker for the pseudocolor palette generator, bound to the top.
// Depends on pseudocolor_palette_generator_defines.svh.
`include "pseudocolor_palette_generator_defines.svh"

module ppg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_we,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    `PPG_ASSERT_NEXT(a_out_held, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `PPG_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")
    // A configuration write restarts the constant derivation, which blocks requests.
    `PPG_ASSERT_NEXT(a_cfg_block, cfg_we, !s_tready, "request taken right after config write")
    `PPG_ASSERT_NOW(a_cfg_block2, $past(cfg_we, 2), !s_tready, "request taken during derivation")

endmodule

bind pseudocolor_palette_generator ppg_checker u_ppg_checker (
    .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
